[rtl/smpq_pkg.sv]
// Package for the scale-mask pitch quantizer.
// Holds the voltage constants, register codes, stage structs and the scale search helpers.
// Used by smpq_scale, smpq_select and scale_mask_pitch_quantizer.
package smpq_pkg;

    localparam int NOTE_COUNT  = 12;
    localparam int VOLT_W      = 17;
    localparam int QMAG_W      = 8;
    localparam int NOTE_W      = 6;
    localparam int DIST_W      = 4;

    localparam logic signed [VOLT_W-1:0] VOLT_MAX = 17'sd36864;
    localparam logic signed [VOLT_W-1:0] VOLT_MIN = -17'sd36864;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_MASK   = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd2;

    // Scale mode codes.
    localparam logic [1:0] MODE_HALF  = 2'd0;
    localparam logic [1:0] MODE_FIFTH = 2'd1;
    localparam logic [1:0] MODE_TENTH = 2'd2;

    typedef logic signed [VOLT_W-1:0] volt_t;
    typedef logic signed [NOTE_W-1:0] note_t;

    // Rounded semitone magnitude and its sign, between the two stages.
    typedef struct packed {
        logic [QMAG_W-1:0] q_mag;
        logic              neg;
    } scale_res_t;

    // Chosen note and the output value of one item.
    typedef struct packed {
        note_t octave;
        note_t semi;
        logic  changed;
        volt_t quant;
    } note_res_t;

    // Distance upward from residue r to the first enabled semitone, NOTE_COUNT if none.
    function automatic logic [DIST_W-1:0] find_up(input logic [NOTE_COUNT-1:0] mask,
                                                  input logic [DIST_W-1:0] r);
        logic [DIST_W-1:0] d;
        logic [DIST_W:0]   idx;
        d = DIST_W'(NOTE_COUNT);
        for (int k = NOTE_COUNT - 1; k >= 0; k--)
        begin
            idx = {1'b0, r} + (DIST_W + 1)'(k);
            if (idx >= (DIST_W + 1)'(NOTE_COUNT))
            begin
                idx = idx - (DIST_W + 1)'(NOTE_COUNT);
            end
            if (mask[idx[DIST_W-1:0]])
            begin
                d = DIST_W'(k);
            end
        end
        return d;
    endfunction

    // Distance downward from residue r to the first enabled semitone, NOTE_COUNT if none.
    function automatic logic [DIST_W-1:0] find_down(input logic [NOTE_COUNT-1:0] mask,
                                                    input logic [DIST_W-1:0] r);
        logic [DIST_W-1:0] d;
        logic [DIST_W:0]   idx;
        d = DIST_W'(NOTE_COUNT);
        for (int k = NOTE_COUNT - 1; k >= 0; k--)
        begin
            idx = {1'b0, r} + (DIST_W + 1)'(NOTE_COUNT) - (DIST_W + 1)'(k);
            if (idx >= (DIST_W + 1)'(NOTE_COUNT))
            begin
                idx = idx - (DIST_W + 1)'(NOTE_COUNT);
            end
            if (mask[idx[DIST_W-1:0]])
            begin
                d = DIST_W'(k);
            end
        end
        return d;
    endfunction

endpackage

[rtl/smpq_scale.sv]
// First stage of the quantizer: source select, mode scaling, saturation and rounding.
// Produces the rounded semitone magnitude and sign; depends on smpq_pkg.
module smpq_scale
    import smpq_pkg::*;
(
    input  volt_t      pitch_volts,
    input  logic       pitch_present,
    input  volt_t      noise_volts,
    input  volt_t      transpose_volts,
    input  logic [1:0] scale_mode,
    input  logic       scale_enable,
    output scale_res_t res
);

    typedef enum logic [1:0] {DIV_ONE, DIV_TWO, DIV_FIVE, DIV_TEN} div_t;

    div_t                div_sel;
    logic signed [20:0]  x_ext;
    logic signed [20:0]  t_ext;
    logic signed [20:0]  dt;
    logic signed [20:0]  num;
    logic signed [20:0]  lim;
    logic signed [20:0]  num_c;
    logic signed [20:0]  mag_s;
    logic [18:0]         mag;
    logic [18:0]         half;
    logic [18:0]         tsum;
    logic [10:0]         v;
    logic [10:0]         v5;
    logic [21:0]         prod5;
    logic [QMAG_W-1:0]   q;

    // The scaled sum is x + d*transpose with d in {1, 2, 5, 10}, so the
    // divide by 256*d that follows stays exact.
    always_comb
    begin
        if (pitch_present && !scale_enable)
        begin
            div_sel = DIV_ONE;
        end
        else
        begin
            case (scale_mode)
                MODE_HALF:  div_sel = DIV_TWO;
                MODE_FIFTH: div_sel = DIV_FIVE;
                MODE_TENTH: div_sel = DIV_TEN;
                default:    div_sel = DIV_ONE;
            endcase
        end
    end

    assign x_ext = pitch_present ? 21'(pitch_volts) : 21'(noise_volts);
    assign t_ext = 21'(transpose_volts);

    always_comb
    begin
        case (div_sel)
            DIV_TWO:
            begin
                dt   = t_ext <<< 1;
                lim  = 21'sd73728;
                half = 19'd256;
            end
            DIV_FIVE:
            begin
                dt   = (t_ext <<< 2) + t_ext;
                lim  = 21'sd184320;
                half = 19'd640;
            end
            DIV_TEN:
            begin
                dt   = (t_ext <<< 3) + (t_ext <<< 1);
                lim  = 21'sd368640;
                half = 19'd1280;
            end
            default:
            begin
                dt   = t_ext;
                lim  = 21'sd36864;
                half = 19'd128;
            end
        endcase
    end

    assign num = x_ext + dt;

    always_comb
    begin
        if (num > lim)
        begin
            num_c = lim;
        end
        else if (num < -lim)
        begin
            num_c = -lim;
        end
        else
        begin
            num_c = num;
        end
    end

    assign mag_s = num_c[20] ? -num_c : num_c;
    assign mag   = mag_s[18:0];
    assign tsum  = mag + half;
    assign v     = tsum[18:8];

    // Divide by five as a multiply by ceil(2^13/5); exact for values below 2730.
    assign v5    = (div_sel == DIV_TEN) ? (v >> 1) : v;
    assign prod5 = 22'(v5) * 22'd1639;

    always_comb
    begin
        case (div_sel)
            DIV_TWO:  q = QMAG_W'(v >> 1);
            DIV_FIVE: q = prod5[13 +: QMAG_W];
            DIV_TEN:  q = prod5[13 +: QMAG_W];
            default:  q = v[QMAG_W-1:0];
        endcase
    end

    assign res.q_mag = q;
    assign res.neg   = num_c[20];

endmodule

[rtl/smpq_select.sv]
// Second stage of the quantizer: octave split, scale mask search and output sum.
// Pure logic; the caller holds the previous note state. Depends on smpq_pkg.
module smpq_select
    import smpq_pkg::*;
(
    input  scale_res_t            sr,
    input  volt_t                 offset_volts,
    input  logic [NOTE_COUNT-1:0] scale_mask,
    input  note_t                 prev_octave,
    input  note_t                 prev_semi,
    output note_res_t             res
);

    logic [15:0]       oct_prod;
    logic [3:0]        oct_mag;
    logic [7:0]        oct_x12;
    logic [7:0]        rem_full;
    logic [3:0]        rem;
    note_t             octave0;
    note_t             semi0;
    logic [DIST_W-1:0] residue;
    logic [DIST_W-1:0] up;
    logic [DIST_W-1:0] down;
    note_t             octave;
    note_t             semi;
    logic signed [18:0] sum;

    // Divide by twelve as a multiply by ceil(2^11/12); exact below 512.
    assign oct_prod = 16'(sr.q_mag) * 16'd171;
    assign oct_mag  = oct_prod[14:11];
    assign oct_x12  = (8'(oct_mag) << 3) + (8'(oct_mag) << 2);
    assign rem_full = sr.q_mag - oct_x12;
    assign rem      = rem_full[3:0];

    // Both quotient and remainder truncate toward zero.
    assign octave0 = sr.neg ? -note_t'(oct_mag) : note_t'(oct_mag);
    assign semi0   = sr.neg ? -note_t'(rem) : note_t'(rem);

    assign residue = (sr.neg && rem != 4'd0) ? DIST_W'(NOTE_COUNT) - rem : rem;
    assign up      = find_up(scale_mask, residue);
    assign down    = find_down(scale_mask, residue);

    // An empty mask keeps the previous note; otherwise the nearer enabled
    // semitone wins and a tie goes upward, without wrapping the octave.
    always_comb
    begin
        if (scale_mask == '0)
        begin
            octave = prev_octave;
            semi   = prev_semi;
        end
        else if (up > down)
        begin
            octave = octave0;
            semi   = semi0 - note_t'(down);
        end
        else
        begin
            octave = octave0;
            semi   = semi0 + note_t'(up);
        end
    end

    assign sum = (19'(octave) <<< 11) + (19'(octave) <<< 10) + (19'(semi) <<< 8)
               + 19'(offset_volts);

    always_comb
    begin
        if (sum > 19'(VOLT_MAX))
        begin
            res.quant = VOLT_MAX;
        end
        else if (sum < 19'(VOLT_MIN))
        begin
            res.quant = VOLT_MIN;
        end
        else
        begin
            res.quant = sum[VOLT_W-1:0];
        end
    end

    assign res.octave  = octave;
    assign res.semi    = semi;
    assign res.changed = (octave != prev_octave) || (semi != prev_semi);

endmodule

[rtl/scale_mask_pitch_quantizer.sv]
// Top level of the scale-mask pitch quantizer: stream ports, register port and pipeline.
// Instantiates smpq_scale and smpq_select; depends on smpq_pkg.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid / s_tready  s_tdata (72 bits), s_tuser (1 bit)
//   m_*       out        m_tvalid / m_tready  m_tdata (40 bits)
//   APB       in         psel, penable, pwrite, pready (always high); paddr 4 bits
//
// Three register stages: an input register, a stage after the scaling and rounding, and
// the result register. An item is offered on m_* once it reaches the result register, and
// one item is taken every cycle while the output is drained. A stall on m_tready holds
// a stage only while the stage after it is full, so bubbles close up. The previous note and
// the sample-and-hold state change as an item enters the result register. Reset clears the
// valid bits, the configuration and the note state.
module scale_mask_pitch_quantizer
    import smpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [16:0] pitch_volts, [33:17] noise_volts, [50:34] transpose_volts,
    // [67:51] offset_volts, [68] trigger_edge, [71:69] zero
    input  logic [71:0] s_tdata,
    // [0] pitch_present
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [16:0] quantized_volts, [33:17] held_volts, [34] note_changed, [39:35] zero
    output logic [39:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [NOTE_COUNT-1:0] mask_reg;
    logic [1:0]            mode_reg;
    logic                  enable_reg;
    logic                  cfg_wr;

    // Input register.
    logic  v1_reg;
    volt_t pitch1_reg;
    volt_t noise1_reg;
    volt_t transpose1_reg;
    volt_t offset1_reg;
    logic  present1_reg;
    logic  trig1_reg;

    // Middle register.
    logic       v2_reg;
    scale_res_t sr2_reg;
    volt_t      offset2_reg;
    logic       trig2_reg;

    // Result register and item state.
    logic  v3_reg;
    volt_t quant3_reg;
    logic  changed3_reg;
    volt_t held_reg;
    volt_t held_next;
    logic  pending_reg;
    logic  pending_next;
    note_t prev_oct_reg;
    note_t prev_semi_reg;

    logic       st1_ready;
    logic       st2_ready;
    logic       st3_ready;
    logic       load3;
    scale_res_t sr1;
    note_res_t  nr2;

    // Each stage takes a new item when it is empty or its item moves on.
    assign st3_ready = !v3_reg || m_tready;
    assign st2_ready = !v2_reg || st3_ready;
    assign st1_ready = !v1_reg || st2_ready;
    assign s_tready  = st1_ready;
    assign load3     = v2_reg && st3_ready;

    // Register port: writes land on the access cycle; reads are combinational.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_MASK:   prdata = 32'(mask_reg);
            REG_MODE:   prdata = 32'(mode_reg);
            REG_ENABLE: prdata = 32'(enable_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            mode_reg   <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MASK:   mask_reg   <= pwdata[NOTE_COUNT-1:0];
                REG_MODE:   mode_reg   <= pwdata[1:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    smpq_scale u_scale (
        .pitch_volts     (pitch1_reg),
        .pitch_present   (present1_reg),
        .noise_volts     (noise1_reg),
        .transpose_volts (transpose1_reg),
        .scale_mode      (mode_reg),
        .scale_enable    (enable_reg),
        .res             (sr1)
    );

    smpq_select u_select (
        .sr           (sr2_reg),
        .offset_volts (offset2_reg),
        .scale_mask   (mask_reg),
        .prev_octave  (prev_oct_reg),
        .prev_semi    (prev_semi_reg),
        .res          (nr2)
    );

    // A pending trigger makes this item's quantized value the held value;
    // a trigger on this item arms the next one.
    always_comb
    begin
        held_next    = pending_reg ? nr2.quant : held_reg;
        pending_next = trig2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            held_reg      <= '0;
            pending_reg   <= 1'b0;
            prev_oct_reg  <= '0;
            prev_semi_reg <= '0;
        end
        else
        begin
            if (st1_ready)
            begin
                v1_reg <= s_tvalid;
            end
            if (st2_ready)
            begin
                v2_reg <= v1_reg;
            end
            if (st3_ready)
            begin
                v3_reg <= v2_reg;
            end
            if (load3)
            begin
                held_reg      <= held_next;
                pending_reg   <= pending_next;
                prev_oct_reg  <= nr2.octave;
                prev_semi_reg <= nr2.semi;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (st1_ready && s_tvalid)
        begin
            pitch1_reg     <= s_tdata[16:0];
            noise1_reg     <= s_tdata[33:17];
            transpose1_reg <= s_tdata[50:34];
            offset1_reg    <= s_tdata[67:51];
            trig1_reg      <= s_tdata[68];
            present1_reg   <= s_tuser[0];
        end
        if (st2_ready && v1_reg)
        begin
            sr2_reg     <= sr1;
            offset2_reg <= offset1_reg;
            trig2_reg   <= trig1_reg;
        end
        if (load3)
        begin
            quant3_reg   <= nr2.quant;
            changed3_reg <= nr2.changed;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {5'b0, changed3_reg, held_reg, quant3_reg};

    // A free output side never holds back the input side.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // An item in the middle stage reaches the output once it may move.
    a_item_advances: assert property (@(posedge clk) disable iff (!rst_n)
        load3 |=> m_tvalid)
        else $error("item lost between middle and result stage");

    // The delivered voltage stays within the saturation limits.
    a_quant_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (quant3_reg <= VOLT_MAX && quant3_reg >= VOLT_MIN))
        else $error("quantized voltage out of range");

    // With an empty mask the note is kept, so no change is reported.
    a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (load3 && mask_reg == '0) |=> !changed3_reg)
        else $error("note change reported with an empty mask");

endmodule
